FILE: hdl/quadratic_intensity_model_fit_core_assert.svh
// Assertion macros for the quadratic intensity model fit core.
// Used by quadratic_intensity_model_fit_core; needs signals clock and reset in scope.
`ifndef QUADRATIC_INTENSITY_MODEL_FIT_CORE_ASSERT_SVH
`define QUADRATIC_INTENSITY_MODEL_FIT_CORE_ASSERT_SVH
`ifndef SYNTH
`define QIMF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define QIMF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define QIMF_ASSERT_SAME(lbl, ante, cons, msg)
`define QIMF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/qimf_pkg.sv
// Shared types, codes and helpers for the quadratic intensity model fit core.
// No dependencies.
`timescale 1ns / 1ps
package qimf_pkg;
   typedef logic signed [31:0] q16_type;
   typedef logic [1:0] action_type;

   localparam action_type ACT_LOAD   = 2'd0;
   localparam action_type ACT_SAMPLE = 2'd1;
   localparam action_type ACT_CLEAR  = 2'd2;

   localparam int SUM_W = 52;
   localparam q16_type ONE_Q16 = 32'sh0001_0000;
   localparam logic [47:0] DIST_MAX = 48'hFFFF_FFFF_FFFF;

   function automatic q16_type sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction
endpackage

FILE: hdl/quadratic_intensity_model_fit_core.sv
// Quadratic intensity model fit core: top level, sequencer and memories.
// Depends on qimf_pkg and quadratic_intensity_model_fit_core_assert.svh.
//
// Usage: the req channel (valid/ready) carries one transaction per action.
// Load writes one coefficient table slot, clear zeroes the distance sum,
// sample stores one mode value and accumulates it into every channel.
// csr_wr_en/csr_wr_data write iref at once; the user must write it only
// while the block is idle, the block itself does not enforce this. A
// sample value makes one pass of the shared multiplier per channel around
// the coefficient memory read. On end_of_sample the end phase adds each
// channel's constant coefficient, squares the amplitude and sums it, then
// forms the residual and distance; then 1 + CHANNELS*(1+MODES) results
// leave on the rsp channel, the first at once, each of the rest after a
// mode memory read and a multiply, the last flagged by rsp_last_of_run.
// req_ready is high only between transactions. A stalled receiver holds
// the rsp register and the sequencer waits on it; nothing is dropped.
// Reset clears iref, the distance sum, the amplitude sums and the mode
// store valid bits; the coefficient table holds garbage until loaded.
`timescale 1ns / 1ps
module quadratic_intensity_model_fit_core #(
   parameter int CHANNELS = 4,
   parameter int MODES    = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic signed [31:0]    csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [5:0]            req_coeff_index,
   input  logic signed [31:0]    req_coeff_value,
   input  logic [2:0]            req_mode_index,
   input  logic signed [31:0]    req_mode_value,
   input  logic                  req_end_of_sample,
   input  logic signed [31:0]    req_measured_intensity,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [5:0]            rsp_grad_index,
   output logic signed [31:0]    rsp_grad_value,
   output logic signed [31:0]    rsp_intensity,
   output logic signed [32:0]    rsp_residual,
   output logic [47:0]           rsp_distance,
   output logic                  rsp_last_of_run
);
   localparam int SLOTS = CHANNELS * (1 + MODES);
   localparam int SW = $clog2(SLOTS);
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MW = (MODES > 1) ? $clog2(MODES) : 1;
   localparam int KW = $clog2(MODES + 1);
   localparam int GW = $clog2(SLOTS + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_MAC_RD   = 4'd1;
   localparam logic [3:0] S_MAC_MUL  = 4'd2;
   localparam logic [3:0] S_MAC_ACC  = 4'd3;
   localparam logic [3:0] S_END_RD   = 4'd4;
   localparam logic [3:0] S_END_AMP  = 4'd5;
   localparam logic [3:0] S_END_SQ   = 4'd6;
   localparam logic [3:0] S_END_SUM  = 4'd7;
   localparam logic [3:0] S_RES      = 4'd8;
   localparam logic [3:0] S_DIST_MUL = 4'd9;
   localparam logic [3:0] S_DIST     = 4'd10;
   localparam logic [3:0] S_GRD_RD   = 4'd11;
   localparam logic [3:0] S_GRD_MUL  = 4'd12;
   localparam logic [3:0] S_GRD_OUT  = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] chan_ff, chan_in;
   logic [KW-1:0] gk_ff, gk_in;
   logic [GW-1:0] g_ff, g_in;
   qimf_pkg::q16_type iref_ff, iref_in;
   logic [47:0] dist_ff, dist_in;
   logic signed [47:0] acc_ff [CHANNELS];
   logic signed [47:0] acc_in [CHANNELS];
   logic [MODES-1:0] mode_vld_ff, mode_vld_in;
   logic rsp_valid_ff, rsp_valid_in;

   qimf_pkg::q16_type x_ff, x_in;
   logic [2:0] midx_ff, midx_in;
   logic eos_ff, eos_in;
   qimf_pkg::q16_type meas_ff, meas_in;
   qimf_pkg::q16_type amp_ff [CHANNELS];
   qimf_pkg::q16_type amp_in [CHANNELS];
   qimf_pkg::q16_type amp_cur_ff, amp_cur_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [qimf_pkg::SUM_W-1:0] sum_ff, sum_in;
   qimf_pkg::q16_type inten_ff, inten_in;
   logic signed [32:0] resid_ff, resid_in;
   logic [65:0] sq_ff, sq_in;
   logic [5:0] rsp_idx_ff, rsp_idx_in;
   qimf_pkg::q16_type rsp_gv_ff, rsp_gv_in;
   qimf_pkg::q16_type rsp_int_ff, rsp_int_in;
   logic signed [32:0] rsp_res_ff, rsp_res_in;
   logic [47:0] rsp_dist_ff, rsp_dist_in;
   logic rsp_last_ff, rsp_last_in;

   qimf_pkg::q16_type coeff_mem [SLOTS];
   qimf_pkg::q16_type coeff_q_ff;
   logic [SW-1:0] coeff_raddr;
   qimf_pkg::q16_type mode_mem [MODES];
   qimf_pkg::q16_type mode_q_ff;
   logic mode_qv_ff;
   logic [MW-1:0] mode_raddr;

   logic req_fire;
   logic mode_ok;
   logic signed [48:0] acc_sum;
   logic signed [48:0] amp_sum;
   qimf_pkg::q16_type inten_c;
   logic [32:0] mag;
   logic [50:0] dist_sum;
   qimf_pkg::q16_type mode_val;
   qimf_pkg::q16_type grad_c;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire = req_valid && req_ready;
   assign mode_ok = (int'(req_mode_index) < MODES);

   assign coeff_raddr = (state_ff == S_END_RD) ?
      SW'(int'(chan_ff) * (MODES + 1)) :
      SW'(int'(chan_ff) * (MODES + 1) + 1 + int'(midx_ff));
   assign mode_raddr = MW'(gk_ff - KW'(1));

   // coefficient table
   always_ff @(posedge clock) begin
      if (req_fire && req_action == qimf_pkg::ACT_LOAD && int'(req_coeff_index) < SLOTS) begin
         coeff_mem[SW'(req_coeff_index)] <= req_coeff_value;
      end
      coeff_q_ff <= coeff_mem[coeff_raddr];
   end

   // mode store
   always_ff @(posedge clock) begin
      if (req_fire && req_action == qimf_pkg::ACT_SAMPLE && mode_ok) begin
         mode_mem[MW'(req_mode_index)] <= req_mode_value;
      end
      mode_q_ff <= mode_mem[mode_raddr];
      mode_qv_ff <= mode_vld_ff[mode_raddr];
   end

   always_comb begin
      acc_sum = {acc_ff[chan_ff][47], acc_ff[chan_ff]}
              + {prod_ff[63], $signed(prod_ff[63:16])};
      amp_sum = {acc_ff[chan_ff][47], acc_ff[chan_ff]} + 49'(coeff_q_ff);
      inten_c = qimf_pkg::sat32(64'(sum_ff));
      mag = resid_ff[32] ? 33'(-resid_ff) : 33'(resid_ff);
      dist_sum = 51'(dist_ff) + 51'(sq_ff[65:16]);
      mode_val = mode_qv_ff ? mode_q_ff : 32'sd0;
      if (g_ff == '0) begin
         grad_c = qimf_pkg::ONE_Q16;
      end else if (gk_ff == '0) begin
         grad_c = qimf_pkg::sat32(64'(amp_ff[chan_ff]) * 64'sd2);
      end else begin
         grad_c = qimf_pkg::sat32(64'($signed(prod_ff[63:15])));
      end
   end

   always_comb begin
      state_in = state_ff;
      chan_in = chan_ff;
      gk_in = gk_ff;
      g_in = g_ff;
      iref_in = csr_wr_en ? csr_wr_data : iref_ff;
      dist_in = dist_ff;
      acc_in = acc_ff;
      mode_vld_in = mode_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      x_in = x_ff;
      midx_in = midx_ff;
      eos_in = eos_ff;
      meas_in = meas_ff;
      amp_in = amp_ff;
      amp_cur_in = amp_cur_ff;
      prod_in = prod_ff;
      sum_in = sum_ff;
      inten_in = inten_ff;
      resid_in = resid_ff;
      sq_in = sq_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_gv_in = rsp_gv_ff;
      rsp_int_in = rsp_int_ff;
      rsp_res_in = rsp_res_ff;
      rsp_dist_in = rsp_dist_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in = req_mode_value;
               midx_in = req_mode_index;
               eos_in = req_end_of_sample;
               meas_in = req_measured_intensity;
               sum_in = qimf_pkg::SUM_W'(iref_ff);
               chan_in = '0;
               unique case (req_action)
                  qimf_pkg::ACT_SAMPLE: begin
                     if (mode_ok) begin
                        mode_vld_in[MW'(req_mode_index)] = 1'b1;
                        state_in = S_MAC_RD;
                     end else if (req_end_of_sample) begin
                        state_in = S_END_RD;
                     end
                  end
                  qimf_pkg::ACT_CLEAR: dist_in = '0;
                  default: ;
               endcase
            end
         end
         S_MAC_RD: state_in = S_MAC_MUL;
         S_MAC_MUL: begin
            prod_in = x_ff * coeff_q_ff;
            state_in = S_MAC_ACC;
         end
         S_MAC_ACC: begin
            if (acc_sum[48] != acc_sum[47]) begin
               acc_in[chan_ff] = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            end else begin
               acc_in[chan_ff] = acc_sum[47:0];
            end
            if (int'(chan_ff) == CHANNELS - 1) begin
               chan_in = '0;
               state_in = eos_ff ? S_END_RD : S_IDLE;
            end else begin
               chan_in = chan_ff + CW'(1);
               state_in = S_MAC_RD;
            end
         end
         S_END_RD: state_in = S_END_AMP;
         S_END_AMP: begin
            amp_in[chan_ff] = qimf_pkg::sat32(64'(amp_sum));
            amp_cur_in = qimf_pkg::sat32(64'(amp_sum));
            state_in = S_END_SQ;
         end
         S_END_SQ: begin
            prod_in = amp_cur_ff * amp_cur_ff;
            state_in = S_END_SUM;
         end
         S_END_SUM: begin
            sum_in = sum_ff + qimf_pkg::SUM_W'($signed(prod_ff[63:16]));
            if (int'(chan_ff) == CHANNELS - 1) begin
               chan_in = '0;
               state_in = S_RES;
            end else begin
               chan_in = chan_ff + CW'(1);
               state_in = S_END_RD;
            end
         end
         S_RES: begin
            inten_in = inten_c;
            resid_in = 33'(meas_ff) - 33'(inten_c);
            state_in = S_DIST_MUL;
         end
         S_DIST_MUL: begin
            sq_in = 66'(mag) * 66'(mag);
            state_in = S_DIST;
         end
         S_DIST: begin
            dist_in = (dist_sum > 51'(qimf_pkg::DIST_MAX)) ? qimf_pkg::DIST_MAX
                                                          : dist_sum[47:0];
            g_in = '0;
            state_in = S_GRD_OUT;
         end
         S_GRD_RD: state_in = S_GRD_MUL;
         S_GRD_MUL: begin
            prod_in = mode_val * amp_ff[chan_ff];
            state_in = S_GRD_OUT;
         end
         S_GRD_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in = 6'(g_ff);
               rsp_gv_in = grad_c;
               rsp_int_in = inten_ff;
               rsp_res_in = resid_ff;
               rsp_dist_in = dist_ff;
               rsp_last_in = (int'(g_ff) == SLOTS);
               if (int'(g_ff) == SLOTS) begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     acc_in[i] = '0;
                  end
                  mode_vld_in = '0;
                  chan_in = '0;
                  state_in = S_IDLE;
               end else begin
                  g_in = g_ff + GW'(1);
                  if (g_ff == '0) begin
                     chan_in = '0;
                     gk_in = '0;
                  end else if (int'(gk_ff) == MODES) begin
                     gk_in = '0;
                     chan_in = chan_ff + CW'(1);
                  end else begin
                     gk_in = gk_ff + KW'(1);
                  end
                  state_in = S_GRD_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chan_ff <= '0;
         gk_ff <= '0;
         g_ff <= '0;
         iref_ff <= '0;
         dist_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            acc_ff[i] <= '0;
         end
         mode_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chan_ff <= chan_in;
         gk_ff <= gk_in;
         g_ff <= g_in;
         iref_ff <= iref_in;
         dist_ff <= dist_in;
         acc_ff <= acc_in;
         mode_vld_ff <= mode_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      midx_ff <= midx_in;
      eos_ff <= eos_in;
      meas_ff <= meas_in;
      amp_ff <= amp_in;
      amp_cur_ff <= amp_cur_in;
      prod_ff <= prod_in;
      sum_ff <= sum_in;
      inten_ff <= inten_in;
      resid_ff <= resid_in;
      sq_ff <= sq_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_gv_ff <= rsp_gv_in;
      rsp_int_ff <= rsp_int_in;
      rsp_res_ff <= rsp_res_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_grad_index = rsp_idx_ff;
   assign rsp_grad_value = rsp_gv_ff;
   assign rsp_intensity = rsp_int_ff;
   assign rsp_residual = rsp_res_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_last_of_run = rsp_last_ff;

`include "quadratic_intensity_model_fit_core_assert.svh"

   `QIMF_ASSERT_NEXT(a_run_restarts, rsp_valid && rsp_ready && rsp_last_of_run, !rsp_valid || rsp_grad_index == 6'd0, "result after last of run")
   `QIMF_ASSERT_SAME(a_head_not_last, rsp_valid && rsp_grad_index == 6'd0, !rsp_last_of_run, "first gradient flagged last")
   `QIMF_ASSERT_SAME(a_idle_chan_zero, state_ff == S_IDLE, chan_ff == '0, "channel counter not rewound")
endmodule
